### hw/rtl/rgbc_pkg.sv
// Shared widths, register codes and stage-to-stage records for the crop block.
package rgbc_pkg;

  localparam int BYTE_W = 8;
  localparam int CFG_W  = 13;
  localparam int IDX_W  = 3;
  localparam int COL_W  = 15;
  localparam int ROW_W  = 14;
  localparam int POS_W  = 16;
  localparam int CLAMP_W = 15;

  localparam int BYTES_PER_PX   = 3;
  localparam int MAX_WIDTH_DEF  = 4096;
  localparam int MAX_HEIGHT_DEF = 4096;

  // geometry pipeline depth after a register write
  localparam int SETTLE_CYCLES = 3;

  typedef enum logic [IDX_W-1:0] {
    REG_SRC_WIDTH = 3'd0,
    REG_CROP_X    = 3'd1,
    REG_CROP_Y    = 3'd2,
    REG_CROP_W    = 3'd3,
    REG_CROP_H    = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [POS_W-1:0] first;
    logic [POS_W-1:0] stop;
    logic [COL_W-1:0] src_row;
    logic [11:0]      crop_y;
    logic [ROW_W-1:0] end_row;
    logic [1:0]       opad;
    logic             any_w;
  } geom_t;

  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] data;
    logic              row_last;
    logic              crop_last;
    logic [1:0]        opad;
  } run_t;

endpackage

### hw/rtl/rgb24_row_padded_crop.sv
// Top level of the 24-bit image crop on a byte stream.
//
//  channel | signals                              | direction
//  in      | in_valid, in_ready, data_byte        | request in
//  out     | out_valid, out_ready, out_byte, flags| request out
//  cfg     | cfg_we, cfg_index, cfg_data          | write only
//
// One byte per cycle in steady state while out_ready is high; the last window
// byte of a row holds the input while its padding bytes go out.
// A register write drops in_ready while the geometry pipeline recomputes.
// Reset restores the register defaults and clears the counters.
// A stalled output holds its request and blocks input only once it is full.
module rgb24_row_padded_crop #(
  parameter int MAX_WIDTH  = rgbc_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = rgbc_pkg::MAX_HEIGHT_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [rgbc_pkg::IDX_W-1:0]  cfg_index,
  input  logic [rgbc_pkg::CFG_W-1:0]  cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [rgbc_pkg::BYTE_W-1:0] data_byte,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [rgbc_pkg::BYTE_W-1:0] out_byte,
  output logic                        is_pad,
  output logic                        row_done,
  output logic                        crop_done,
  output logic                        last_of_run
);
  import rgbc_pkg::*;

  geom_t geom;
  run_t  run;
  logic  settled, free, take;

  assign in_ready = settled && free;
  assign take     = in_valid && in_ready;

  rgbc_geom #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_geom (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .geom     (geom),
    .settled  (settled)
  );

  rgbc_scan u_scan (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .data_byte(data_byte),
    .geom     (geom),
    .run      (run)
  );

  rgbc_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .load       (take && run.valid),
    .run        (run),
    .free       (free),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .is_pad     (is_pad),
    .row_done   (row_done),
    .crop_done  (crop_done),
    .last_of_run(last_of_run)
  );

endmodule

### hw/rtl/rgbc_geom.sv
// Configuration registers and the registered window geometry derived from them.
module rgbc_geom #(
  parameter int MAX_WIDTH  = rgbc_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = rgbc_pkg::MAX_HEIGHT_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [rgbc_pkg::IDX_W-1:0]  cfg_index,
  input  logic [rgbc_pkg::CFG_W-1:0]  cfg_data,
  output rgbc_pkg::geom_t             geom,
  output logic                        settled
);
  import rgbc_pkg::*;

  localparam logic [CLAMP_W-1:0] MaxW = CLAMP_W'(MAX_WIDTH);
  localparam logic [CLAMP_W-1:0] MaxH = CLAMP_W'(MAX_HEIGHT);

  logic [CFG_W-1:0] src_width, crop_w, crop_h;
  logic [11:0]      crop_x, crop_y;
  logic [1:0]       settle;

  // stage 1
  logic [CFG_W-1:0] s1_cw, s1_ch, s1_ewraw;
  logic [COL_W-1:0] s1_row_px;
  logic [POS_W-1:0] s1_first;
  logic             s1_has_w;
  logic [11:0]      s1_crop_y;
  // stage 2
  logic [CFG_W-1:0] s2_ew;
  logic [COL_W-1:0] s2_src_row;
  logic [ROW_W-1:0] s2_end_row;
  logic [POS_W-1:0] s2_first;
  logic [11:0]      s2_crop_y;

  logic [CFG_W-1:0] sw_next, cw_next, ch_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width <= CFG_W'(1);
      crop_x    <= '0;
      crop_y    <= '0;
      crop_w    <= CFG_W'(1);
      crop_h    <= CFG_W'(1);
      settle    <= 2'(SETTLE_CYCLES);
    end else if (cfg_we) begin
      settle <= 2'(SETTLE_CYCLES);
      unique case (cfg_reg_t'(cfg_index))
        REG_SRC_WIDTH: src_width <= cfg_data;
        REG_CROP_X:    crop_x    <= cfg_data[11:0];
        REG_CROP_Y:    crop_y    <= cfg_data[11:0];
        REG_CROP_W:    crop_w    <= cfg_data;
        REG_CROP_H:    crop_h    <= cfg_data;
        default:       ;
      endcase
    end else if (settle != 2'd0) begin
      settle <= settle - 2'd1;
    end
  end

  assign settled = (settle == 2'd0);

  always_comb begin
    priority if (src_width == '0)                 sw_next = CFG_W'(1);
    else if ({2'b00, src_width} > MaxW)            sw_next = CFG_W'(MaxW);
    else                                           sw_next = src_width;
    cw_next = ({2'b00, crop_w} > MaxW) ? CFG_W'(MaxW) : crop_w;
    ch_next = ({2'b00, crop_h} > MaxH) ? CFG_W'(MaxH) : crop_h;
  end

  always_ff @(posedge clk) begin
    s1_cw     <= cw_next;
    s1_ch     <= ch_next;
    s1_row_px <= COL_W'(sw_next) * COL_W'(BYTES_PER_PX);
    s1_first  <= POS_W'(crop_x) * POS_W'(BYTES_PER_PX);
    s1_has_w  <= {1'b0, crop_x} < sw_next;
    s1_ewraw  <= sw_next - {1'b0, crop_x};
    s1_crop_y <= crop_y;

    // effective width clipped at the source row end
    s2_ew      <= !s1_has_w ? '0 : ((s1_cw < s1_ewraw) ? s1_cw : s1_ewraw);
    s2_src_row <= (s1_row_px + COL_W'(3)) & ~COL_W'(3);
    s2_end_row <= ROW_W'(s1_crop_y) + ROW_W'(s1_ch);
    s2_first   <= s1_first;
    s2_crop_y  <= s1_crop_y;

    geom.first   <= s2_first;
    geom.stop    <= s2_first + POS_W'(s2_ew) * POS_W'(BYTES_PER_PX);
    geom.src_row <= s2_src_row;
    geom.crop_y  <= s2_crop_y;
    geom.end_row <= s2_end_row;
    geom.opad    <= s2_ew[1:0];  // 3*ew padded to four bytes needs ew mod 4
    geom.any_w   <= (s2_ew != '0);
  end

endmodule

### hw/rtl/rgbc_scan.sv
// Byte column and row counters and the window decision for each accepted byte.
module rgbc_scan (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        take,
  input  logic [rgbc_pkg::BYTE_W-1:0] data_byte,
  input  rgbc_pkg::geom_t             geom,
  output rgbc_pkg::run_t              run
);
  import rgbc_pkg::*;

  logic [COL_W-1:0] byte_column, byte_column_next;
  logic [ROW_W-1:0] row_index, row_index_next;
  logic             finished, finished_next;

  logic [POS_W-1:0] col_w, col_inc;
  logic [ROW_W:0]   row_inc;
  logic             done_now, in_win, row_last, crop_last, row_end;

  always_comb begin
    col_w     = POS_W'(byte_column);
    col_inc   = col_w + POS_W'(1);
    row_inc   = {1'b0, row_index} + (ROW_W+1)'(1);
    done_now  = finished || (row_index >= geom.end_row);
    in_win    = (row_index >= ROW_W'(geom.crop_y)) && geom.any_w &&
                (col_w >= geom.first) && (col_w < geom.stop);
    row_last  = (col_inc == geom.stop);
    crop_last = row_last && (row_inc == {1'b0, geom.end_row});
    row_end   = (col_inc >= POS_W'(geom.src_row));

    run.valid     = !done_now && in_win;
    run.data      = data_byte;
    run.row_last  = row_last;
    run.crop_last = crop_last;
    run.opad      = geom.opad;

    byte_column_next = byte_column;
    row_index_next   = row_index;
    finished_next    = finished;
    if (done_now) begin
      finished_next = 1'b1;
    end else begin
      if (in_win && crop_last) finished_next = 1'b1;
      if (row_end) begin
        byte_column_next = '0;
        row_index_next   = row_inc[ROW_W-1:0];
        if (row_inc >= {1'b0, geom.end_row}) finished_next = 1'b1;
      end else begin
        byte_column_next = col_inc[COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_column <= '0;
      row_index   <= '0;
      finished    <= 1'b0;
    end else if (take) begin
      byte_column <= byte_column_next;
      row_index   <= row_index_next;
      finished    <= finished_next;
    end
  end

endmodule

### hw/rtl/rgbc_emit.sv
// Result register: sends the window byte, then any inserted row padding bytes.
module rgbc_emit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        load,
  input  rgbc_pkg::run_t              run,
  output logic                        free,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [rgbc_pkg::BYTE_W-1:0] out_byte,
  output logic                        is_pad,
  output logic                        row_done,
  output logic                        crop_done,
  output logic                        last_of_run
);
  import rgbc_pkg::*;

  logic [1:0] pad_left;
  logic       crop_tail;
  logic       pad_fin;

  assign free    = !out_valid || (out_ready && pad_left == 2'd0);
  assign pad_fin = (pad_left == 2'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pad_left  <= '0;
    end else if (load) begin
      out_valid <= 1'b1;
      pad_left  <= run.row_last ? run.opad : 2'd0;
    end else if (out_valid && out_ready) begin
      if (pad_left != 2'd0) pad_left  <= pad_left - 2'd1;
      else                  out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte    <= run.data;
      is_pad      <= 1'b0;
      row_done    <= run.row_last && run.opad == 2'd0;
      crop_done   <= run.crop_last && run.opad == 2'd0;
      last_of_run <= !run.row_last || run.opad == 2'd0;
      crop_tail   <= run.crop_last;
    end else if (out_valid && out_ready && pad_left != 2'd0) begin
      out_byte    <= '0;
      is_pad      <= 1'b1;
      row_done    <= pad_fin;
      crop_done   <= crop_tail && pad_fin;
      last_of_run <= pad_fin;
    end
  end

endmodule

### hw/rtl/rgbc_check.sv
// Port-level checks for the crop block, bound to the top level.
module rgbc_check (
  input logic                        clk,
  input logic                        rst,
  input logic                        cfg_we,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [rgbc_pkg::BYTE_W-1:0] out_byte,
  input logic                        is_pad,
  input logic                        row_done,
  input logic                        crop_done,
  input logic                        last_of_run
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(is_pad))
    else $error("output request changed while stalled");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_pad |-> out_byte == 8'h00)
    else $error("padding byte not zero");

  a_crop_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && crop_done |-> row_done && last_of_run)
    else $error("crop end without row end");

  a_run_cont: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_of_run |=> out_valid && is_pad)
    else $error("run cut short before its padding");

  a_cfg_stall: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> !in_ready)
    else $error("input taken while geometry settles");

endmodule

bind rgb24_row_padded_crop rgbc_check u_check (
  .clk        (clk),
  .rst        (rst),
  .cfg_we     (cfg_we),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_byte   (out_byte),
  .is_pad     (is_pad),
  .row_done   (row_done),
  .crop_done  (crop_done),
  .last_of_run(last_of_run)
);
